### design/pts_pkg.sv
package pts_pkg;

   localparam int LINE_BITS   = 24;
   localparam int LENGTH_BITS = 16;
   localparam int MAX_RESULTS = 6;
   localparam int RADIX_TOP   = 36;

   localparam logic [7:0] RADIX_MARK = 8'h23;
   localparam logic [7:0] META_MARK  = 8'h24;
   localparam logic [6:0] NO_DIGIT   = 7'd99;

   localparam logic [3:0] K_IDENT = 4'd0;
   localparam logic [3:0] K_INT   = 4'd1;
   localparam logic [3:0] K_REAL  = 4'd2;
   localparam logic [3:0] K_CHAR  = 4'd3;
   localparam logic [3:0] K_STR   = 4'd4;
   localparam logic [3:0] K_PUNCT = 4'd5;
   localparam logic [3:0] K_META  = 4'd6;
   localparam logic [3:0] K_EOF   = 4'd7;
   localparam logic [3:0] K_ERR   = 4'd8;

   localparam logic [2:0] E_NONE    = 3'd0;
   localparam logic [2:0] E_COMMENT = 3'd1;
   localparam logic [2:0] E_STRING  = 3'd2;
   localparam logic [2:0] E_RADIX   = 3'd3;
   localparam logic [2:0] E_CHAR    = 3'd4;

   localparam logic [4:0] P_NONE   = 5'd0;
   localparam logic [4:0] P_LPAR   = 5'd1;
   localparam logic [4:0] P_RPAR   = 5'd2;
   localparam logic [4:0] P_LBRK   = 5'd3;
   localparam logic [4:0] P_RBRK   = 5'd4;
   localparam logic [4:0] P_COMMA  = 5'd5;
   localparam logic [4:0] P_SEMI   = 5'd6;
   localparam logic [4:0] P_COLON  = 5'd7;
   localparam logic [4:0] P_ASSIGN = 5'd8;
   localparam logic [4:0] P_DOT    = 5'd9;
   localparam logic [4:0] P_RANGE  = 5'd10;
   localparam logic [4:0] P_CARET  = 5'd11;
   localparam logic [4:0] P_PLUS   = 5'd12;
   localparam logic [4:0] P_MINUS  = 5'd13;
   localparam logic [4:0] P_STAR   = 5'd14;
   localparam logic [4:0] P_SLASH  = 5'd15;
   localparam logic [4:0] P_EQ     = 5'd16;
   localparam logic [4:0] P_NE     = 5'd17;
   localparam logic [4:0] P_LT     = 5'd18;
   localparam logic [4:0] P_LE     = 5'd19;
   localparam logic [4:0] P_GT     = 5'd20;
   localparam logic [4:0] P_GE     = 5'd21;

   typedef struct packed {
      logic [7:0] src_byte;
      logic       end_of_source;
   } item_type;

   typedef struct packed {
      logic                   record_kind;
      logic [3:0]             token_kind;
      logic [4:0]             punct_code;
      logic [2:0]             error_code;
      logic signed [63:0]     int_value;
      logic [7:0]             raw_char;
      logic [7:0]             lower_char;
      logic [LINE_BITS-1:0]   line_number;
      logic [LENGTH_BITS-1:0] text_length;
      logic                   last_of_run;
   } res_type;

   function automatic logic is_dig(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) || (c == 8'h5F);
   endfunction

   function automatic logic [7:0] fold(input logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) ? c + 8'd32 : c;
   endfunction

   function automatic logic [6:0] digit_val(input logic [7:0] c);
      logic [6:0] v;
      v = NO_DIGIT;
      if (is_dig(c)) v = 7'(c - 8'h30);
      else if ((c >= 8'h61) && (c <= 8'h7A)) v = 7'(c - 8'h61 + 8'd10);
      else if ((c >= 8'h41) && (c <= 8'h5A)) v = 7'(c - 8'h41 + 8'd10);
      return v;
   endfunction

   function automatic logic [4:0] punct_one(input logic [7:0] c);
      logic [4:0] p;
      case (c)
         8'h28:   p = P_LPAR;
         8'h29:   p = P_RPAR;
         8'h5B:   p = P_LBRK;
         8'h5D:   p = P_RBRK;
         8'h2C:   p = P_COMMA;
         8'h3B:   p = P_SEMI;
         8'h5E:   p = P_CARET;
         8'h2B:   p = P_PLUS;
         8'h2D:   p = P_MINUS;
         8'h2A:   p = P_STAR;
         8'h2F:   p = P_SLASH;
         8'h3D:   p = P_EQ;
         default: p = P_NONE;
      endcase
      return p;
   endfunction

   function automatic res_type mk_text(input logic [7:0] c, input logic [7:0] low,
                                       input logic [LINE_BITS-1:0] line,
                                       input logic [LENGTH_BITS-1:0] len);
      res_type r;
      r = '0;
      r.raw_char    = c;
      r.lower_char  = low;
      r.line_number = line;
      r.text_length = len;
      return r;
   endfunction

   function automatic res_type mk_tok(input logic [3:0] tk, input logic [4:0] pc,
                                      input logic [2:0] ec, input logic [63:0] iv,
                                      input logic [LINE_BITS-1:0] line,
                                      input logic [LENGTH_BITS-1:0] len);
      res_type r;
      r = '0;
      r.record_kind = 1'b1;
      r.token_kind  = tk;
      r.punct_code  = pc;
      r.error_code  = ec;
      r.int_value   = iv;
      r.line_number = line;
      r.text_length = len;
      return r;
   endfunction

endpackage

### design/pts_in_queue.sv
module pts_in_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  pts_pkg::item_type din,
   input  logic              pop,
   output logic              empty,
   output pts_pkg::item_type dout
);

   pts_pkg::item_type slot_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign dout    = slot_ff[rp_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wp_in  = wp_ff ^ do_push;
      rp_in  = rp_ff ^ do_pop;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wp_ff] <= din;
   end

endmodule

### design/pts_out_queue.sv
module pts_out_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  pts_pkg::res_type din,
   input  logic             pop,
   output logic             empty,
   output pts_pkg::res_type dout
);

   pts_pkg::res_type slot_ff [4];
   logic [1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full    = (cnt_ff == 3'd4);
   assign empty   = (cnt_ff == 3'd0);
   assign dout    = slot_ff[rp_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wp_in  = wp_ff + 2'(do_push);
      rp_in  = rp_ff + 2'(do_pop);
      cnt_in = cnt_ff + 3'(do_push) - 3'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 2'd0;
         rp_ff  <= 2'd0;
         cnt_ff <= 3'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wp_ff] <= din;
   end

endmodule

### design/pts_scan_core.sv
module pts_scan_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  pts_pkg::item_type in_item,
   output logic              in_take,
   input  logic              out_room,
   output logic              out_push,
   output pts_pkg::res_type  out_res
);

   localparam int LB = pts_pkg::LINE_BITS;
   localparam int NB = pts_pkg::LENGTH_BITS;

   typedef enum logic [3:0] {
      SQ_WAIT = 4'b0001,
      SQ_RUN  = 4'b0010,
      SQ_FIN  = 4'b0100,
      SQ_EOF  = 4'b1000
   } seq_type;

   typedef enum logic [9:0] {
      MD_IDLE  = 10'b0000000001,
      MD_IDENT = 10'b0000000010,
      MD_INT   = 10'b0000000100,
      MD_RADIX = 10'b0000001000,
      MD_FRAC  = 10'b0000010000,
      MD_EXP   = 10'b0000100000,
      MD_ESIGN = 10'b0001000000,
      MD_STR   = 10'b0010000000,
      MD_BRACE = 10'b0100000000,
      MD_PAREN = 10'b1000000000
   } mode_type;

   seq_type          seq_ff, seq_in;
   mode_type         mode_ff, mode_in;
   logic [7:0]       la_ff [3];
   logic [7:0]       la_in [3];
   logic [1:0]       cnt_ff, cnt_in;
   logic [63:0]      accum_ff, accum_in;
   logic [5:0]       radix_ff, radix_in;
   logic [LB-1:0]    line_ff, line_in, tline_ff, tline_in, ltl_ff, ltl_in;
   logic [NB-1:0]    len_ff, len_in;
   logic             first_ff, first_in, meta_ff, meta_in, digit_ff, digit_in;
   logic             halted_ff, halted_in, fin_ff, fin_in;
   logic [2:0]       ocnt_ff, ocnt_in;
   pts_pkg::res_type stg_ff, stg_in;
   logic             stg_v_ff, stg_v_in;

   logic             em, brk, take, stall, do_fail, do_close, do_expo, do_endc, do_body;
   logic [1:0]       drop;
   logic [2:0]       fcode;
   logic [LB-1:0]    tl, line_inc;
   logic [NB-1:0]    len_inc;
   pts_pkg::res_type er;
   logic [7:0]       c, p1, p2;
   logic             have1, have2, d1dig, d2dig;
   logic [67:0]      dec;
   logic [69:0]      rprod;
   logic [6:0]       dv;
   logic [63:0]      base64;
   logic [4:0]       pc;
   logic             two;

   assign c        = la_ff[0];
   assign p1       = la_ff[1];
   assign p2       = la_ff[2];
   assign have1    = cnt_ff > 2'd1;
   assign have2    = cnt_ff > 2'd2;
   assign d1dig    = have1 && pts_pkg::is_dig(p1);
   assign d2dig    = have2 && pts_pkg::is_dig(p2);
   assign line_inc = (&line_ff) ? line_ff : line_ff + 1'b1;
   assign len_inc  = (&len_ff) ? len_ff : len_ff + 1'b1;
   assign dec      = ({4'd0, accum_ff} << 3) + ({4'd0, accum_ff} << 1) + 68'(c - 8'h30);
   assign rprod    = accum_ff * radix_ff;
   assign dv       = pts_pkg::digit_val(c);
   assign base64   = (accum_ff > 64'd63) ? 64'd63 : accum_ff;

   always_comb begin
      seq_in = seq_ff;   mode_in = mode_ff;   la_in = la_ff;     cnt_in = cnt_ff;
      accum_in = accum_ff; radix_in = radix_ff; line_in = line_ff; tline_in = tline_ff;
      ltl_in = ltl_ff;   len_in = len_ff;     first_in = first_ff; meta_in = meta_ff;
      digit_in = digit_ff; halted_in = halted_ff; fin_in = fin_ff; ocnt_in = ocnt_ff;
      stg_in = stg_ff;   stg_v_in = stg_v_ff;
      em = 1'b0; er = '0; brk = 1'b0; take = 1'b0; drop = 2'd0; out_push = 1'b0;
      out_res = stg_ff;
      do_fail = 1'b0; do_close = 1'b0; do_expo = 1'b0; do_endc = 1'b0; do_body = 1'b0;
      fcode = pts_pkg::E_NONE; tl = tline_ff; pc = pts_pkg::P_NONE; two = 1'b0;

      unique case (seq_ff)
         SQ_WAIT: begin
            if (stg_v_ff) begin
               out_push = 1'b1;
               out_res.last_of_run = 1'b1;
               stg_v_in = 1'b0;
            end
            if (in_valid) begin
               take    = 1'b1;
               ocnt_in = 3'd0;
               fin_in  = in_item.end_of_source;
               if (halted_ff) begin
                  seq_in = in_item.end_of_source ? SQ_FIN : SQ_WAIT;
               end else begin
                  la_in[cnt_ff] = in_item.src_byte;
                  cnt_in = cnt_ff + 2'd1;
                  seq_in = SQ_RUN;
               end
            end
         end
         SQ_RUN: begin
            unique case (mode_ff)
               MD_IDENT: begin
                  if (pts_pkg::is_alpha(c) || pts_pkg::is_dig(c)) begin
                     em = 1'b1; er = pts_pkg::mk_text(c, pts_pkg::fold(c), tline_ff, len_inc);
                     len_in = len_inc; drop = 2'd1;
                  end else begin
                     em = 1'b1; er = pts_pkg::mk_tok(pts_pkg::K_IDENT, pts_pkg::P_NONE,
                        pts_pkg::E_NONE, 64'd0, tline_ff, len_ff);
                     ltl_in = tline_ff; mode_in = MD_IDLE;
                  end
               end
               MD_INT: begin
                  if (pts_pkg::is_dig(c)) begin
                     accum_in = (|dec[67:64]) ? '1 : dec[63:0];
                     em = 1'b1; er = pts_pkg::mk_text(c, c, tline_ff, len_inc);
                     len_in = len_inc; drop = 2'd1;
                  end else if (c == pts_pkg::RADIX_MARK) begin
                     radix_in = base64[5:0];
                     if (base64 < 64'd2 || base64 > 64'(pts_pkg::RADIX_TOP)) begin
                        do_fail = 1'b1; fcode = pts_pkg::E_RADIX;
                     end else begin
                        em = 1'b1; er = pts_pkg::mk_text(c, c, tline_ff, len_inc);
                        len_in = len_inc; drop = 2'd1; accum_in = '0;
                        first_in = 1'b0; meta_in = 1'b0; digit_in = 1'b0; mode_in = MD_RADIX;
                     end
                  end else if (c == 8'h2E) begin
                     if (!have1 && !fin_ff) brk = 1'b1;
                     else if (d1dig) begin
                        em = 1'b1; er = pts_pkg::mk_text(c, c, tline_ff, len_inc);
                        len_in = len_inc; drop = 2'd1; mode_in = MD_FRAC;
                     end else do_close = 1'b1;
                  end else if (c == 8'h65 || c == 8'h45) do_expo = 1'b1;
                  else do_close = 1'b1;
               end
               MD_FRAC: begin
                  if (pts_pkg::is_dig(c)) begin
                     em = 1'b1; er = pts_pkg::mk_text(c, c, tline_ff, len_inc);
                     len_in = len_inc; drop = 2'd1;
                  end else if (c == 8'h65 || c == 8'h45) do_expo = 1'b1;
                  else do_close = 1'b1;
               end
               MD_EXP: begin
                  if (pts_pkg::is_dig(c)) begin
                     em = 1'b1; er = pts_pkg::mk_text(c, c, tline_ff, len_inc);
                     len_in = len_inc; drop = 2'd1;
                  end else do_close = 1'b1;
               end
               MD_ESIGN: begin
                  em = 1'b1; er = pts_pkg::mk_text(c, c, tline_ff, len_inc);
                  len_in = len_inc; drop = 2'd1; mode_in = MD_EXP;
               end
               MD_RADIX: begin
                  if (dv < {1'b0, radix_ff}) begin
                     accum_in = rprod[63:0] + 64'(dv);
                     digit_in = 1'b1;
                     em = 1'b1; er = pts_pkg::mk_text(c, c, tline_ff, len_inc);
                     len_in = len_inc; drop = 2'd1;
                  end else if (digit_ff) begin
                     first_in = 1'b0; meta_in = 1'b0; digit_in = 1'b0; do_close = 1'b1;
                  end else begin
                     do_fail = 1'b1; fcode = pts_pkg::E_RADIX;
                  end
               end
               MD_STR: begin
                  if (c == 8'h0A) begin
                     do_fail = 1'b1; fcode = pts_pkg::E_STRING;
                  end else if (c == 8'h27) begin
                     if (!have1 && !fin_ff) brk = 1'b1;
                     else if (have1 && p1 == 8'h27) begin
                        em = 1'b1; er = pts_pkg::mk_text(c, c, tline_ff, len_inc);
                        len_in = len_inc; accum_in = 64'(c); drop = 2'd2;
                     end else begin
                        drop = 2'd1; em = 1'b1; ltl_in = tline_ff; mode_in = MD_IDLE;
                        if (len_ff == NB'(1))
                           er = pts_pkg::mk_tok(pts_pkg::K_CHAR, pts_pkg::P_NONE,
                              pts_pkg::E_NONE, accum_ff, tline_ff, len_ff);
                        else
                           er = pts_pkg::mk_tok(pts_pkg::K_STR, pts_pkg::P_NONE,
                              pts_pkg::E_NONE, 64'd0, tline_ff, len_ff);
                     end
                  end else begin
                     em = 1'b1; er = pts_pkg::mk_text(c, c, tline_ff, len_inc);
                     len_in = len_inc; accum_in = 64'(c); drop = 2'd1;
                  end
               end
               MD_BRACE: begin
                  if (c == 8'h7D) begin
                     drop = 2'd1; do_endc = 1'b1;
                  end else do_body = 1'b1;
               end
               MD_PAREN: begin
                  if (c == 8'h2A && !have1 && !fin_ff) brk = 1'b1;
                  else if (c == 8'h2A && have1 && p1 == 8'h29) begin
                     drop = 2'd2; do_endc = 1'b1;
                  end else do_body = 1'b1;
               end
               default: begin
                  if (c == 8'h0A) begin
                     line_in = line_inc; drop = 2'd1;
                  end else if (c == 8'h20 || (c >= 8'd9 && c <= 8'd13)) begin
                     drop = 2'd1;
                  end else if (c == 8'h7B) begin
                     tline_in = line_ff; mode_in = MD_BRACE;
                     first_in = 1'b1; meta_in = 1'b0; digit_in = 1'b0; drop = 2'd1;
                  end else if (c == 8'h28 && !have1 && !fin_ff) begin
                     brk = 1'b1;
                  end else if (c == 8'h28 && have1 && p1 == 8'h2A) begin
                     tline_in = line_ff; mode_in = MD_PAREN;
                     first_in = 1'b1; meta_in = 1'b0; digit_in = 1'b0; drop = 2'd2;
                  end else if (pts_pkg::is_alpha(c) || pts_pkg::is_dig(c) || c == 8'h27) begin
                     tline_in = line_ff; len_in = '0; accum_in = '0;
                     if (pts_pkg::is_alpha(c)) mode_in = MD_IDENT;
                     else if (pts_pkg::is_dig(c)) mode_in = MD_INT;
                     else begin
                        mode_in = MD_STR; drop = 2'd1;
                     end
                  end else if ((c == 8'h3A || c == 8'h2E || c == 8'h3C || c == 8'h3E)
                               && !have1 && !fin_ff) begin
                     brk = 1'b1;
                  end else begin
                     pc = pts_pkg::punct_one(c);
                     if (c == 8'h3A) begin
                        two = have1 && p1 == 8'h3D;
                        pc  = two ? pts_pkg::P_ASSIGN : pts_pkg::P_COLON;
                     end else if (c == 8'h2E) begin
                        two = have1 && p1 == 8'h2E;
                        pc  = two ? pts_pkg::P_RANGE : pts_pkg::P_DOT;
                     end else if (c == 8'h3C) begin
                        two = have1 && (p1 == 8'h3E || p1 == 8'h3D);
                        pc  = !two ? pts_pkg::P_LT :
                              (p1 == 8'h3E) ? pts_pkg::P_NE : pts_pkg::P_LE;
                     end else if (c == 8'h3E) begin
                        two = have1 && p1 == 8'h3D;
                        pc  = two ? pts_pkg::P_GE : pts_pkg::P_GT;
                     end
                     tline_in = line_ff; tl = line_ff;
                     if (pc == pts_pkg::P_NONE) begin
                        do_fail = 1'b1; fcode = pts_pkg::E_CHAR;
                     end else begin
                        em = 1'b1; er = pts_pkg::mk_tok(pts_pkg::K_PUNCT, pc,
                           pts_pkg::E_NONE, 64'd0, line_ff, '0);
                        ltl_in = line_ff; mode_in = MD_IDLE;
                        drop = two ? 2'd2 : 2'd1;
                     end
                  end
               end
            endcase

            // An exponent letter is taken only when a digit, or a sign and a digit, follow.
            if (do_expo) begin
               if (!have1 && !fin_ff) brk = 1'b1;
               else if (d1dig) begin
                  em = 1'b1; er = pts_pkg::mk_text(c, c, tline_ff, len_inc);
                  len_in = len_inc; drop = 2'd1; mode_in = MD_EXP;
               end else if (have1 && (p1 == 8'h2B || p1 == 8'h2D)) begin
                  if (!have2 && !fin_ff) brk = 1'b1;
                  else if (d2dig) begin
                     em = 1'b1; er = pts_pkg::mk_text(c, c, tline_ff, len_inc);
                     len_in = len_inc; drop = 2'd1; mode_in = MD_ESIGN;
                  end else do_close = 1'b1;
               end else do_close = 1'b1;
            end
            if (do_endc) begin
               if (meta_ff) begin
                  em = 1'b1; er = pts_pkg::mk_tok(pts_pkg::K_META, pts_pkg::P_NONE,
                     pts_pkg::E_NONE, 64'd0, tline_ff, '0);
                  ltl_in = tline_ff;
               end
               first_in = 1'b0; meta_in = 1'b0; digit_in = 1'b0; mode_in = MD_IDLE;
            end
            if (do_body) begin
               if (first_ff && c == pts_pkg::META_MARK) meta_in = 1'b1;
               first_in = 1'b0;
               if (c == 8'h0A) line_in = line_inc;
               drop = 2'd1;
            end
            if (drop == 2'd1) begin
               la_in[0] = la_ff[1]; la_in[1] = la_ff[2]; la_in[2] = 8'd0;
               cnt_in = cnt_ff - 2'd1;
            end else if (drop == 2'd2) begin
               la_in[0] = la_ff[2]; la_in[1] = 8'd0; la_in[2] = 8'd0;
               cnt_in = cnt_ff - 2'd2;
            end
         end
         SQ_FIN: begin
            seq_in = SQ_EOF;
            if (!halted_ff) begin
               unique case (mode_ff)
                  MD_IDENT: begin
                     em = 1'b1; er = pts_pkg::mk_tok(pts_pkg::K_IDENT, pts_pkg::P_NONE,
                        pts_pkg::E_NONE, 64'd0, tline_ff, len_ff);
                     ltl_in = tline_ff;
                  end
                  MD_INT, MD_FRAC, MD_EXP, MD_ESIGN: do_close = 1'b1;
                  MD_RADIX: begin
                     if (digit_ff) do_close = 1'b1;
                     else begin
                        do_fail = 1'b1; fcode = pts_pkg::E_RADIX;
                     end
                  end
                  MD_STR: begin
                     do_fail = 1'b1; fcode = pts_pkg::E_STRING;
                  end
                  MD_BRACE, MD_PAREN: begin
                     do_fail = 1'b1; fcode = pts_pkg::E_COMMENT;
                  end
                  default: ;
               endcase
            end
         end
         SQ_EOF: begin
            em = 1'b1; er = pts_pkg::mk_tok(pts_pkg::K_EOF, pts_pkg::P_NONE,
               pts_pkg::E_NONE, 64'd0, ltl_ff, '0);
            seq_in = SQ_WAIT; mode_in = MD_IDLE;
            la_in[0] = 8'd0; la_in[1] = 8'd0; la_in[2] = 8'd0; cnt_in = 2'd0;
            accum_in = '0; radix_in = '0; line_in = LB'(1); tline_in = LB'(1);
            ltl_in = LB'(1); len_in = '0; first_in = 1'b0; meta_in = 1'b0;
            digit_in = 1'b0; halted_in = 1'b0;
         end
         default: seq_in = SQ_WAIT;
      endcase

      if (do_close) begin
         em = 1'b1; ltl_in = tline_ff; mode_in = MD_IDLE;
         if (mode_ff == MD_FRAC || mode_ff == MD_EXP)
            er = pts_pkg::mk_tok(pts_pkg::K_REAL, pts_pkg::P_NONE, pts_pkg::E_NONE,
               64'd0, tline_ff, len_ff);
         else
            er = pts_pkg::mk_tok(pts_pkg::K_INT, pts_pkg::P_NONE, pts_pkg::E_NONE,
               accum_ff, tline_ff, len_ff);
      end
      if (do_fail) begin
         em = 1'b1; er = pts_pkg::mk_tok(pts_pkg::K_ERR, pts_pkg::P_NONE, fcode,
            64'd0, tl, '0);
         ltl_in = tl; halted_in = 1'b1; mode_in = MD_IDLE; cnt_in = 2'd0;
         la_in[0] = 8'd0; la_in[1] = 8'd0; la_in[2] = 8'd0;
      end

      if (seq_ff == SQ_RUN) begin
         if (brk || halted_in || cnt_in == 2'd0) seq_in = fin_ff ? SQ_FIN : SQ_WAIT;
      end

      // The newest result waits in a holding stage until it is known whether it ends the run.
      if (em && ocnt_ff < 3'(pts_pkg::MAX_RESULTS)) begin
         if (stg_v_ff) out_push = 1'b1;
         stg_in   = er;
         stg_v_in = 1'b1;
         ocnt_in  = ocnt_ff + 3'd1;
      end

      stall   = out_push && !out_room;
      in_take = take && !stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff    <= SQ_WAIT;
         mode_ff   <= MD_IDLE;
         cnt_ff    <= 2'd0;
         line_ff   <= LB'(1);
         tline_ff  <= LB'(1);
         ltl_ff    <= LB'(1);
         len_ff    <= '0;
         accum_ff  <= '0;
         radix_ff  <= '0;
         first_ff  <= 1'b0;
         meta_ff   <= 1'b0;
         digit_ff  <= 1'b0;
         halted_ff <= 1'b0;
         fin_ff    <= 1'b0;
         ocnt_ff   <= 3'd0;
         stg_v_ff  <= 1'b0;
         la_ff[0]  <= 8'd0;
         la_ff[1]  <= 8'd0;
         la_ff[2]  <= 8'd0;
      end else if (!stall) begin
         seq_ff    <= seq_in;
         mode_ff   <= mode_in;
         cnt_ff    <= cnt_in;
         line_ff   <= line_in;
         tline_ff  <= tline_in;
         ltl_ff    <= ltl_in;
         len_ff    <= len_in;
         accum_ff  <= accum_in;
         radix_ff  <= radix_in;
         first_ff  <= first_in;
         meta_ff   <= meta_in;
         digit_ff  <= digit_in;
         halted_ff <= halted_in;
         fin_ff    <= fin_in;
         ocnt_ff   <= ocnt_in;
         stg_v_ff  <= stg_v_in;
         la_ff     <= la_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) stg_ff <= stg_in;
   end

endmodule

### design/pascal_token_scanner.sv
// Pascal token scanner. Source bytes enter through a two-entry queue (req_push while
// req_full is low), the last byte of a source marked by req_end_of_source. Each byte
// yields a run of up to six result transactions, read from a four-entry result queue
// with rsp_pop while rsp_empty is low; rsp_last_of_run marks the final transaction
// caused by a byte. A byte is first taken up, then triggers its scanning steps,
// typically one or two; a byte that ends a source then passes a closing step for the
// closing token and a step for the end-of-file transaction. The single scanning
// sequencer in the back end runs these steps; it holds when a result meets a full queue.
module pascal_token_scanner (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [7:0]                          req_src_byte,
   input  logic                                req_end_of_source,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic                                rsp_record_kind,
   output logic [3:0]                          rsp_token_kind,
   output logic [4:0]                          rsp_punct_code,
   output logic [2:0]                          rsp_error_code,
   output logic signed [63:0]                  rsp_int_value,
   output logic [7:0]                          rsp_raw_char,
   output logic [7:0]                          rsp_lower_char,
   output logic [pts_pkg::LINE_BITS-1:0]       rsp_line_number,
   output logic [pts_pkg::LENGTH_BITS-1:0]     rsp_text_length,
   output logic                                rsp_last_of_run
);

   pts_pkg::item_type in_din, in_dout;
   pts_pkg::res_type  core_res, out_dout;
   logic              in_empty, in_take, out_full, out_push;

   // The front queue takes source bytes while the scanner is busy with earlier ones.
   assign in_din.src_byte      = req_src_byte;
   assign in_din.end_of_source = req_end_of_source;

   pts_in_queue u_in (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .full  (req_full),
      .din   (in_din),
      .pop   (in_take),
      .empty (in_empty),
      .dout  (in_dout)
   );

   pts_scan_core u_core (
      .clock    (clock),
      .reset    (reset),
      .in_valid (!in_empty),
      .in_item  (in_dout),
      .in_take  (in_take),
      .out_room (!out_full),
      .out_push (out_push),
      .out_res  (core_res)
   );

   // The result queue lets the scanner carry on while a consumer is slow.
   pts_out_queue u_out (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .full  (out_full),
      .din   (core_res),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .dout  (out_dout)
   );

   assign rsp_record_kind = out_dout.record_kind;
   assign rsp_token_kind  = out_dout.token_kind;
   assign rsp_punct_code  = out_dout.punct_code;
   assign rsp_error_code  = out_dout.error_code;
   assign rsp_int_value   = out_dout.int_value;
   assign rsp_raw_char    = out_dout.raw_char;
   assign rsp_lower_char  = out_dout.lower_char;
   assign rsp_line_number = out_dout.line_number;
   assign rsp_text_length = out_dout.text_length;
   assign rsp_last_of_run = out_dout.last_of_run;

endmodule
